### hw/rtl/keypad_code_lock_controller_unit_assert.svh
// Assertion macros for the keypad code lock RTL.
// KCL_ASSERT_IMPL checks an overlapping implication on each clock edge.
// KCL_ASSERT_NEXT checks a next-cycle implication on each clock edge.
// Both are disabled while reset is asserted (active low).
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_UNIT_ASSERT_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define KCL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KCL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define KCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hw/rtl/kcl_pkg.sv
`default_nettype none

package kcl_pkg;

    localparam int CODE_W      = 32;
    localparam int LEN_W       = 4;
    localparam int DUR_W       = 20;
    localparam int FLASH_W     = 16;
    localparam int KEY_W       = 4;
    localparam int EV_W        = 4;
    localparam int FAIL_W      = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODE_DIGITS      = 3'd0,
        CFG_CODE_LENGTH      = 3'd1,
        CFG_ENTRY_LIMIT      = 3'd2,
        CFG_ATTEMPT_LIMIT    = 3'd3,
        CFG_LOCKOUT_TICKS    = 3'd4,
        CFG_OPEN_TICKS       = 3'd5,
        CFG_FLASH_HALF_TICKS = 3'd6
    } t_cfg_idx;

    // event reported with each result
    typedef enum logic [EV_W-1:0] {
        EV_NONE             = 4'd0,
        EV_GRANTED          = 4'd1,
        EV_WRONG            = 4'd2,
        EV_LOCKOUT_BEGUN    = 4'd3,
        EV_REFUSED_LOCKED   = 4'd4,
        EV_EMPTY_SUBMIT     = 4'd5,
        EV_NOTHING_TO_CLEAR = 4'd6,
        EV_ATTEMPTS_RESET   = 4'd7,
        EV_NO_ATTEMPTS      = 4'd8
    } t_event;

    localparam logic              KIND_TICK      = 1'b0;
    localparam logic [KEY_W-1:0]  KEY_LAST_DIGIT = 4'd9;
    localparam logic [KEY_W-1:0]  KEY_STAR       = 4'd10;
    localparam logic [KEY_W-1:0]  KEY_HASH       = 4'd11;
    localparam logic [KEY_W-1:0]  KEY_C          = 4'd14;
    localparam logic [FAIL_W-1:0] FAIL_MAX       = 4'd15;
    localparam logic [FLASH_W-1:0] FLASH_MAX     = 16'hFFFF;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key_code;
    } t_in_item;

    typedef struct packed {
        logic              door_open;
        logic              led_on;
        logic              lockout_active;
        logic [3:0]        entered_count;
        logic [FAIL_W-1:0] failed_count;
        logic [DUR_W-1:0]  remaining_ticks;
        logic [EV_W-1:0]   event_res;
    } t_out_item;

    typedef struct packed {
        logic [CODE_W-1:0]  code_digits;
        logic [LEN_W-1:0]   code_length;
        logic [LEN_W-1:0]   entry_limit;
        logic [LEN_W-1:0]   attempt_limit;
        logic [DUR_W-1:0]   lockout_ticks;
        logic [DUR_W-1:0]   open_ticks;
        logic [FLASH_W-1:0] flash_half_ticks;
    } t_cfg;

endpackage

`default_nettype wire

### hw/rtl/keypad_code_lock_controller_unit.sv
// Keypad code lock controller. Each input transfer is either a one-millisecond
// tick or a key press, and each one yields exactly one result transfer that
// carries the door, LED and lockout status, the entry and failure counts, the
// time left on the active timer and an event code. The block takes one item
// per clock cycle while the output side does not stall: the whole state
// update (entry buffer, counters, timers) is a single combinational step
// between the input register and the result register. The result register
// parts the two sides, so the input register can still take one new item
// while a finished result waits. No clearing pass runs after reset; the
// entry buffer needs none because only digits entered since the last clear
// are ever compared. Write configuration registers only while no item is
// in flight; the configuration port is always ready.

`default_nettype none

`include "keypad_code_lock_controller_unit_assert.svh"

module keypad_code_lock_controller_unit #(
    parameter int MAX_DIGITS = 8,
    parameter int TIMER_BITS = 20
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire kcl_pkg::t_in_item              i_in_data,

    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output kcl_pkg::t_out_item                  o_out_data,

    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [kcl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [kcl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // input stage
    logic               r_s1_valid;
    kcl_pkg::t_in_item  r_s1_item;

    // result stage
    logic               r_out_valid;
    kcl_pkg::t_out_item r_out_data;

    logic               w_adv;
    logic               w_fire;
    kcl_pkg::t_cfg      w_cfg;
    kcl_pkg::t_out_item w_result;

    // The result register can take a new value when empty or when its current
    // value is being taken this cycle.
    assign w_adv  = !r_out_valid || !i_out_stall;
    // Process the held item and commit its state update.
    assign w_fire = r_s1_valid && w_adv;
    // Hold off the sender only while the held item cannot move on.
    assign o_in_stall = r_s1_valid && !w_adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= w_result;
        end
    end

    kcl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    kcl_core #(
        .MAX_DIGITS (MAX_DIGITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_s1_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The door never opens during a lockout, and a lockout never starts with
    // the door open.
    `KCL_ASSERT_IMPL(a_open_xor_lock, i_clk, i_rst_n, o_out_valid, !(o_out_data.door_open && o_out_data.lockout_active), "door open during lockout")
    // LED is steady on whenever the door is closed.
    `KCL_ASSERT_IMPL(a_led_closed, i_clk, i_rst_n, o_out_valid && !o_out_data.door_open, o_out_data.led_on, "LED off with door closed")
    // No timer running means nothing left to count.
    `KCL_ASSERT_IMPL(a_rem_idle, i_clk, i_rst_n, o_out_valid && !o_out_data.door_open && !o_out_data.lockout_active, o_out_data.remaining_ticks == '0, "remaining ticks without timer")
    // A processed item always lands in the result register.
    `KCL_ASSERT_NEXT(a_fire_lands, i_clk, i_rst_n, w_fire, r_out_valid, "processed item lost")

endmodule

`default_nettype wire

### hw/rtl/kcl_cfg.sv
`default_nettype none

module kcl_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [kcl_pkg::CFG_IDX_W-1:0] i_index,
    input  wire logic [kcl_pkg::CFG_DATA_W-1:0] i_data,
    output kcl_pkg::t_cfg                      o_cfg
);

    kcl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_digits      <= 32'h0000_1234;
            r_cfg.code_length      <= 4'd4;
            r_cfg.entry_limit      <= 4'd8;
            r_cfg.attempt_limit    <= 4'd3;
            r_cfg.lockout_ticks    <= 20'd30000;
            r_cfg.open_ticks       <= 20'd10000;
            r_cfg.flash_half_ticks <= 16'd250;
        end else if (i_wr_en) begin
            case (kcl_pkg::t_cfg_idx'(i_index))
                kcl_pkg::CFG_CODE_DIGITS: begin
                    r_cfg.code_digits <= i_data;
                end
                kcl_pkg::CFG_CODE_LENGTH: begin
                    r_cfg.code_length <= i_data[kcl_pkg::LEN_W-1:0];
                end
                kcl_pkg::CFG_ENTRY_LIMIT: begin
                    r_cfg.entry_limit <= i_data[kcl_pkg::LEN_W-1:0];
                end
                kcl_pkg::CFG_ATTEMPT_LIMIT: begin
                    r_cfg.attempt_limit <= i_data[kcl_pkg::LEN_W-1:0];
                end
                kcl_pkg::CFG_LOCKOUT_TICKS: begin
                    r_cfg.lockout_ticks <= i_data[kcl_pkg::DUR_W-1:0];
                end
                kcl_pkg::CFG_OPEN_TICKS: begin
                    r_cfg.open_ticks <= i_data[kcl_pkg::DUR_W-1:0];
                end
                kcl_pkg::CFG_FLASH_HALF_TICKS: begin
                    r_cfg.flash_half_ticks <= i_data[kcl_pkg::FLASH_W-1:0];
                end
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hw/rtl/kcl_core.sv
`default_nettype none

module kcl_core #(
    parameter int MAX_DIGITS = 8,
    parameter int TIMER_BITS = 20
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire kcl_pkg::t_in_item   i_item,
    input  wire kcl_pkg::t_cfg       i_cfg,
    output kcl_pkg::t_out_item       o_result
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CMP_W = (TIMER_BITS > kcl_pkg::DUR_W) ? TIMER_BITS : kcl_pkg::DUR_W;
    localparam int LIM_W = 5;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    logic [kcl_pkg::KEY_W-1:0]   r_entry [MAX_DIGITS];
    logic [CNT_W-1:0]            r_count;
    logic [kcl_pkg::FAIL_W-1:0]  r_fail;
    logic                        r_open;
    logic                        r_lock;
    logic                        r_led;
    logic [TIMER_BITS-1:0]       r_open_el;
    logic [TIMER_BITS-1:0]       r_lock_el;
    logic [kcl_pkg::FLASH_W-1:0] r_flash_el;

    logic [CNT_W-1:0]            n_count;
    logic [kcl_pkg::FAIL_W-1:0]  n_fail;
    logic                        n_open;
    logic                        n_lock;
    logic                        n_led;
    logic [TIMER_BITS-1:0]       n_open_el;
    logic [TIMER_BITS-1:0]       n_lock_el;
    logic [kcl_pkg::FLASH_W-1:0] n_flash_el;
    logic                        n_wr_en;
    kcl_pkg::t_event             n_event;

    logic [4*MAX_DIGITS-1:0]     w_code_ext;
    logic [MAX_DIGITS-1:0]       w_digit_ok;
    logic                        w_match;
    logic [LIM_W-1:0]            w_limit;
    logic [kcl_pkg::DUR_W-1:0]   w_remaining;

    function automatic logic [kcl_pkg::DUR_W-1:0] ticks_left(
        input logic [kcl_pkg::DUR_W-1:0] lim,
        input logic [TIMER_BITS-1:0]     el
    );
        logic [CMP_W-1:0] lim_x;
        logic [CMP_W-1:0] el_x;
        lim_x = CMP_W'(lim);
        el_x  = CMP_W'(el);
        if (el_x >= lim_x) begin
            return '0;
        end
        return kcl_pkg::DUR_W'(lim_x - el_x);
    endfunction

    // code digits past the eighth read as zero
    assign w_code_ext = (4 * MAX_DIGITS)'(i_cfg.code_digits);

    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            w_digit_ok[i] = (CNT_W'(i) >= r_count) || (r_entry[i] == w_code_ext[4*i +: 4]);
        end
    end

    assign w_match = (i_cfg.code_length != '0)
                  && (LIM_W'(r_count) == LIM_W'(i_cfg.code_length))
                  && (&w_digit_ok);

    assign w_limit = (LIM_W'(i_cfg.entry_limit) < LIM_W'(MAX_DIGITS))
                   ? LIM_W'(i_cfg.entry_limit) : LIM_W'(MAX_DIGITS);

    always_comb begin
        n_count    = r_count;
        n_fail     = r_fail;
        n_open     = r_open;
        n_lock     = r_lock;
        n_led      = r_led;
        n_open_el  = r_open_el;
        n_lock_el  = r_lock_el;
        n_flash_el = r_flash_el;
        n_wr_en    = 1'b0;
        n_event    = kcl_pkg::EV_NONE;

        if (i_item.kind == kcl_pkg::KIND_TICK) begin
            if (r_lock) begin
                n_lock_el = (r_lock_el == TMAX) ? TMAX : r_lock_el + 1'b1;
                if (CMP_W'(n_lock_el) >= CMP_W'(i_cfg.lockout_ticks)) begin
                    n_lock  = 1'b0;
                    n_fail  = '0;
                    n_count = '0;
                end
            end
            if (r_open) begin
                n_open_el  = (r_open_el == TMAX) ? TMAX : r_open_el + 1'b1;
                n_flash_el = (r_flash_el == kcl_pkg::FLASH_MAX)
                           ? kcl_pkg::FLASH_MAX : r_flash_el + 1'b1;
                if (n_flash_el >= i_cfg.flash_half_ticks) begin
                    n_led      = !r_led;
                    n_flash_el = '0;
                end
                if (CMP_W'(n_open_el) >= CMP_W'(i_cfg.open_ticks)) begin
                    n_open = 1'b0;
                    n_led  = 1'b1;
                end
            end
        end else if (!r_open) begin
            if (i_item.key_code <= kcl_pkg::KEY_LAST_DIGIT) begin
                if (LIM_W'(r_count) < w_limit) begin
                    n_wr_en = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end else if (i_item.key_code == kcl_pkg::KEY_STAR) begin
                if (r_count != '0) begin
                    n_count = '0;
                end else begin
                    n_event = kcl_pkg::EV_NOTHING_TO_CLEAR;
                end
            end else if (i_item.key_code == kcl_pkg::KEY_HASH) begin
                if (r_count == '0) begin
                    n_event = kcl_pkg::EV_EMPTY_SUBMIT;
                end else if (r_lock) begin
                    n_event = kcl_pkg::EV_REFUSED_LOCKED;
                end else if (w_match) begin
                    n_fail     = '0;
                    n_open     = 1'b1;
                    n_open_el  = '0;
                    n_flash_el = '0;
                    n_count    = '0;
                    n_event    = kcl_pkg::EV_GRANTED;
                end else begin
                    n_fail  = (r_fail == kcl_pkg::FAIL_MAX) ? r_fail : r_fail + 1'b1;
                    n_count = '0;
                    if (n_fail >= i_cfg.attempt_limit) begin
                        n_lock    = 1'b1;
                        n_lock_el = '0;
                        n_event   = kcl_pkg::EV_LOCKOUT_BEGUN;
                    end else begin
                        n_event = kcl_pkg::EV_WRONG;
                    end
                end
            end else if (i_item.key_code == kcl_pkg::KEY_C) begin
                if (r_fail != '0) begin
                    n_fail  = '0;
                    n_event = kcl_pkg::EV_ATTEMPTS_RESET;
                end else begin
                    n_event = kcl_pkg::EV_NO_ATTEMPTS;
                end
            end
        end
    end

    always_comb begin
        if (n_lock) begin
            w_remaining = ticks_left(i_cfg.lockout_ticks, n_lock_el);
        end else if (n_open) begin
            w_remaining = ticks_left(i_cfg.open_ticks, n_open_el);
        end else begin
            w_remaining = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_fail     <= '0;
            r_open     <= 1'b0;
            r_lock     <= 1'b0;
            r_led      <= 1'b1;
            r_open_el  <= '0;
            r_lock_el  <= '0;
            r_flash_el <= '0;
        end else if (i_fire) begin
            r_count    <= n_count;
            r_fail     <= n_fail;
            r_open     <= n_open;
            r_lock     <= n_lock;
            r_led      <= n_led;
            r_open_el  <= n_open_el;
            r_lock_el  <= n_lock_el;
            r_flash_el <= n_flash_el;
        end
    end

    // entry digits: written in place, no reset
    always_ff @(posedge i_clk) begin
        if (i_fire && n_wr_en) begin
            r_entry[r_count[IDX_W-1:0]] <= i_item.key_code;
        end
    end

    always_comb begin
        o_result.door_open       = n_open;
        o_result.led_on          = n_led;
        o_result.lockout_active  = n_lock;
        o_result.entered_count   = 4'(n_count);
        o_result.failed_count    = n_fail;
        o_result.remaining_ticks = w_remaining;
        o_result.event_res       = n_event;
    end

endmodule

`default_nettype wire

### verif/tb_keypad_code_lock_controller_unit.sv
module tb_keypad_code_lock_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic                      KIND_KEY = 1'b1;
    localparam logic [kcl_pkg::KEY_W-1:0] KEY_A    = 4'd12;
    localparam logic [kcl_pkg::KEY_W-1:0] KEY_B    = 4'd13;
    localparam logic [kcl_pkg::KEY_W-1:0] KEY_D    = 4'd15;

    localparam int DIGIT_SLOTS     = 8;
    localparam int LOCK_SETUPS     = 12;
    localparam int ITEMS_PER_SETUP = 130;
    localparam int QUIET_LIMIT     = 2000;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    kcl_pkg::t_in_item              i_in_data   = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    kcl_pkg::t_out_item             o_out_data;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [kcl_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [kcl_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    keypad_code_lock_controller_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Keypad/tick items waiting to be sent, and the lock status each accepted
    // item should produce, oldest first.
    kcl_pkg::t_in_item  key_stream [$];
    kcl_pkg::t_out_item status_due [$];

    // Lock state as the block should hold it.
    kcl_pkg::t_cfg                lock_cfg;
    logic [3:0]                   typed_digit [DIGIT_SLOTS];
    int unsigned                  typed_n;
    logic [kcl_pkg::FAIL_W-1:0]   fail_n;
    bit                           door_f, locked_f, led_f;
    logic [kcl_pkg::DUR_W-1:0]    open_el, lock_el;
    logic [kcl_pkg::FLASH_W-1:0]  flash_el;

    int mismatch_count = 0;
    int results_checked = 0;
    int keys_sent = 0, ticks_sent = 0, stimulus_count = 0;
    int openings = 0, lockouts = 0, refusals = 0, setups_used = 1;
    int idle_odds = 12;
    int send_gap = 0, stall_left = 0, quiet_cycles = 0;

    // Advance the lock by one item and return the status it reports.
    function automatic kcl_pkg::t_out_item lock_step(kcl_pkg::t_in_item it);
        kcl_pkg::t_event    ev;
        int unsigned        lim;
        bit                 hit;
        kcl_pkg::t_out_item r;
        ev = kcl_pkg::EV_NONE;
        r  = '0;
        if (it.kind == kcl_pkg::KIND_TICK) begin
            if (locked_f) begin
                if (lock_el != '1) lock_el++;
                if (lock_el >= lock_cfg.lockout_ticks) begin
                    locked_f = 1'b0;
                    fail_n   = '0;
                    typed_n  = 0;
                end
            end
            if (door_f) begin
                if (open_el != '1) open_el++;
                if (flash_el != kcl_pkg::FLASH_MAX) flash_el++;
                if (flash_el >= lock_cfg.flash_half_ticks) begin
                    led_f    = !led_f;
                    flash_el = '0;
                end
                if (open_el >= lock_cfg.open_ticks) begin
                    door_f = 1'b0;
                    led_f  = 1'b1;
                end
            end
        end else if (!door_f) begin
            if (it.key_code <= kcl_pkg::KEY_LAST_DIGIT) begin
                lim = (lock_cfg.entry_limit < DIGIT_SLOTS) ? lock_cfg.entry_limit : DIGIT_SLOTS;
                if (typed_n < lim) begin
                    typed_digit[typed_n] = it.key_code;
                    typed_n++;
                end
            end else if (it.key_code == kcl_pkg::KEY_STAR) begin
                if (typed_n > 0) typed_n = 0;
                else ev = kcl_pkg::EV_NOTHING_TO_CLEAR;
            end else if (it.key_code == kcl_pkg::KEY_HASH) begin
                if (typed_n == 0) begin
                    ev = kcl_pkg::EV_EMPTY_SUBMIT;
                end else if (locked_f) begin
                    // keep the entry, the submit is simply refused
                    ev = kcl_pkg::EV_REFUSED_LOCKED;
                end else begin
                    hit = (lock_cfg.code_length != 0) && (typed_n == lock_cfg.code_length);
                    for (int i = 0; i < DIGIT_SLOTS; i++)
                        if (i < typed_n && typed_digit[i] != lock_cfg.code_digits[4*i +: 4])
                            hit = 1'b0;
                    typed_n = 0;
                    if (hit) begin
                        fail_n   = '0;
                        door_f   = 1'b1;
                        open_el  = '0;
                        flash_el = '0;
                        ev       = kcl_pkg::EV_GRANTED;
                    end else begin
                        if (fail_n != kcl_pkg::FAIL_MAX) fail_n++;
                        if (fail_n >= lock_cfg.attempt_limit) begin
                            locked_f = 1'b1;
                            lock_el  = '0;
                            ev       = kcl_pkg::EV_LOCKOUT_BEGUN;
                        end else begin
                            ev = kcl_pkg::EV_WRONG;
                        end
                    end
                end
            end else if (it.key_code == kcl_pkg::KEY_C) begin
                if (fail_n != 0) begin
                    fail_n = '0;
                    ev     = kcl_pkg::EV_ATTEMPTS_RESET;
                end else begin
                    ev = kcl_pkg::EV_NO_ATTEMPTS;
                end
            end
        end

        // Time left shows the lockout first, then the open door; a limit
        // lowered below the elapsed count reads as zero.
        if (locked_f)
            r.remaining_ticks = (lock_el >= lock_cfg.lockout_ticks) ? '0
                              : lock_cfg.lockout_ticks - lock_el;
        else if (door_f)
            r.remaining_ticks = (open_el >= lock_cfg.open_ticks) ? '0
                              : lock_cfg.open_ticks - open_el;
        r.door_open      = door_f;
        r.led_on         = led_f;
        r.lockout_active = locked_f;
        r.entered_count  = 4'(typed_n);
        r.failed_count   = fail_n;
        r.event_res      = ev;
        return r;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic push_item(logic kind, logic [kcl_pkg::KEY_W-1:0] key);
        key_stream.push_back('{kind: kind, key_code: key});
        stimulus_count++;
    endtask

    // A code entry: the stored code most of the time, else random digits
    // (possibly none), always closed by a submit.
    task automatic add_attempt(kcl_pkg::t_cfg s);
        int         n;
        bit         right;
        logic [3:0] d;
        right = ($urandom_range(0, 2) != 0);
        n     = right ? s.code_length : $urandom_range(0, 9);
        if ($urandom_range(0, 5) == 0) push_item(KIND_KEY, kcl_pkg::KEY_STAR);
        for (int i = 0; i < n; i++) begin
            d = (right && i < DIGIT_SLOTS) ? s.code_digits[4*i +: 4] : 4'($urandom_range(0, 9));
            if (d > kcl_pkg::KEY_LAST_DIGIT) d = 4'($urandom_range(0, 9));
            push_item(KIND_KEY, d);
            if ($urandom_range(0, 9) == 0) push_item(kcl_pkg::KIND_TICK, 4'($urandom));
        end
        push_item(KIND_KEY, kcl_pkg::KEY_HASH);
    endtask

    // Mostly short tick runs; now and then one long enough to run out a timer.
    task automatic add_ticks(kcl_pkg::t_cfg s);
        int longest, n;
        longest = (s.lockout_ticks > s.open_ticks) ? s.lockout_ticks : s.open_ticks;
        if (longest > 60) longest = 60;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, longest + 2) : $urandom_range(1, 3);
        repeat (n) push_item(kcl_pkg::KIND_TICK, 4'($urandom));
    endtask

    task automatic write_reg(kcl_pkg::t_cfg_idx idx, logic [kcl_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold until every queued item has gone in and every result has come
    // back, then let the pipeline settle.
    task automatic drain_results();
        do begin
            @(posedge i_clk);
            #1;
        end while (key_stream.size() != 0 || i_in_valid || status_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Input driver: hold the payload while stalled, insert idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (key_stream.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= key_stream.pop_front();
                if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                    send_gap <= $urandom_range(1, 10);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure in bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                stall_left <= $urandom_range(1, 10);
        end
    end

    // Predict the status for each accepted input transfer.
    always @(posedge i_clk) begin : predict_status
        kcl_pkg::t_out_item want;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (i_in_data.kind == kcl_pkg::KIND_TICK) ticks_sent++;
            else keys_sent++;
            want = lock_step(i_in_data);
            case (want.event_res)
                kcl_pkg::EV_GRANTED:        openings++;
                kcl_pkg::EV_LOCKOUT_BEGUN:  lockouts++;
                kcl_pkg::EV_REFUSED_LOCKED: refusals++;
                default: ;
            endcase
            status_due.push_back(want);
        end
    end

    // Check each result transfer against the oldest prediction.
    always @(posedge i_clk) begin : check_status
        kcl_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_due.size() == 0) begin
                $error("result transfer with no item outstanding");
                mismatch_count++;
            end else begin
                want = status_due.pop_front();
                compare_field("door_open", want.door_open, o_out_data.door_open);
                compare_field("led_on", want.led_on, o_out_data.led_on);
                compare_field("lockout_active", want.lockout_active, o_out_data.lockout_active);
                compare_field("entered_count", want.entered_count, o_out_data.entered_count);
                compare_field("failed_count", want.failed_count, o_out_data.failed_count);
                compare_field("remaining_ticks", want.remaining_ticks,
                              o_out_data.remaining_ticks);
                compare_field("event_res", want.event_res, o_out_data.event_res);
                results_checked++;
            end
        end
    end

    // Drop the run if no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        kcl_pkg::t_cfg s;
        int            base;
        int            pick;

        lock_cfg = '{code_digits: 32'h1234, code_length: 4'd4, entry_limit: 4'd8,
                     attempt_limit: 4'd3, lockout_ticks: 20'd30000, open_ticks: 20'd10000,
                     flash_half_ticks: 16'd250};
        foreach (typed_digit[i]) typed_digit[i] = '0;
        typed_n  = 0;
        fail_n   = '0;
        door_f   = 1'b0;
        locked_f = 1'b0;
        led_f    = 1'b1;
        open_el  = '0;
        lock_el  = '0;
        flash_el = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        #1;

        // Directed walk on the reset settings: field extremes, idle keys,
        // a full entry, a miss, an attempt reset, the right code, then a key
        // while the door is open.
        push_item(kcl_pkg::KIND_TICK, 4'hF);
        push_item(KIND_KEY, kcl_pkg::KEY_STAR);
        push_item(KIND_KEY, kcl_pkg::KEY_HASH);
        push_item(KIND_KEY, kcl_pkg::KEY_C);
        push_item(KIND_KEY, KEY_A);
        push_item(KIND_KEY, KEY_B);
        push_item(KIND_KEY, KEY_D);
        for (int d = 0; d <= 8; d++) push_item(KIND_KEY, 4'(d));
        push_item(KIND_KEY, kcl_pkg::KEY_STAR);
        push_item(KIND_KEY, kcl_pkg::KEY_LAST_DIGIT);
        push_item(KIND_KEY, kcl_pkg::KEY_HASH);
        push_item(KIND_KEY, kcl_pkg::KEY_C);
        for (int i = 0; i < 4; i++) push_item(KIND_KEY, lock_cfg.code_digits[4*i +: 4]);
        push_item(KIND_KEY, kcl_pkg::KEY_HASH);
        push_item(KIND_KEY, 4'd5);
        push_item(kcl_pkg::KIND_TICK, 4'd0);

        for (int p = 0; p < LOCK_SETUPS; p++) begin
            drain_results();
            pick = $urandom_range(0, 2);
            idle_odds = (p == LOCK_SETUPS - 1) ? 0 : (pick == 0) ? 0 : (pick == 1) ? 3 : 12;
            case (p)
                // every register at zero: no digits, no code, instant timers
                0: s = '0;
                // every register at its top value
                1: s = '1;
                // top open timer, short lockout and flash, with a reachable eight digit code
                2: begin
                    s                  = '1;
                    s.code_digits      = 32'h98765432;
                    s.code_length      = 4'd8;
                    s.lockout_ticks    = 20'd1;
                    s.flash_half_ticks = 16'd1;
                end
                default: begin
                    for (int i = 0; i < DIGIT_SLOTS; i++)
                        s.code_digits[4*i +: 4] = ($urandom_range(0, 9) == 0) ? 4'($urandom)
                                                : 4'($urandom_range(0, 9));
                    s.code_length = ($urandom_range(0, 9) == 0) ? 4'($urandom)
                                  : 4'($urandom_range(1, 8));
                    s.entry_limit = (s.code_length <= 8 && $urandom_range(0, 4) != 0)
                                  ? 4'($urandom_range(s.code_length, 8)) : 4'($urandom);
                    s.attempt_limit = ($urandom_range(0, 7) == 0) ? 4'($urandom)
                                    : 4'($urandom_range(1, 5));
                    s.lockout_ticks    = 20'($urandom_range(0, 30));
                    s.open_ticks       = 20'($urandom_range(0, 30));
                    s.flash_half_ticks = 16'($urandom_range(0, 5));
                end
            endcase
            write_reg(kcl_pkg::CFG_CODE_DIGITS, s.code_digits);
            write_reg(kcl_pkg::CFG_CODE_LENGTH, 32'(s.code_length));
            write_reg(kcl_pkg::CFG_ENTRY_LIMIT, 32'(s.entry_limit));
            write_reg(kcl_pkg::CFG_ATTEMPT_LIMIT, 32'(s.attempt_limit));
            write_reg(kcl_pkg::CFG_LOCKOUT_TICKS, 32'(s.lockout_ticks));
            write_reg(kcl_pkg::CFG_OPEN_TICKS, 32'(s.open_ticks));
            write_reg(kcl_pkg::CFG_FLASH_HALF_TICKS, 32'(s.flash_half_ticks));
            lock_cfg = s;
            setups_used++;
            #1;

            // Mostly code entries, then tick runs, then arbitrary items.
            base = stimulus_count;
            while (stimulus_count - base < ITEMS_PER_SETUP) begin
                pick = $urandom_range(0, 9);
                if (pick < 5) add_attempt(s);
                else if (pick < 8) add_ticks(s);
                else push_item(1'($urandom), 4'($urandom));
            end
        end

        drain_results();
        $display("Checked %0d results from %0d key presses and %0d ticks over %0d settings.",
                 results_checked, keys_sent, ticks_sent, setups_used);
        $display("Door openings %0d, lockouts %0d, submits refused while locked %0d.",
                 openings, lockouts, refusals);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/kcl_pkg.sv
hw/rtl/kcl_cfg.sv
hw/rtl/kcl_core.sv
hw/rtl/keypad_code_lock_controller_unit.sv
verif/tb_keypad_code_lock_controller_unit.sv
